// ----- rtl/mmca_pkg.sv -----
// Package for the Manhattan min-cost assignment unit.
// Holds opcodes, status codes and shared widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mmca_pkg;
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_TARGET = 2'd1;
    localparam logic [1:0] OP_OBJECT = 2'd2;
    localparam logic [1:0] OP_SOLVE  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SHORT    = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam int COST_W = 14;
    localparam int POT_W  = 24;
    localparam logic [POT_W-1:0] BIG_SLACK = {1'b0, {(POT_W-1){1'b1}}};
    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    // Broadcast commands from the controller to the cell row.
    typedef struct packed {
        logic init_solve;   // clear potentials, owners and links
        logic init_aug;     // reset slack, used flags for a new row
        logic scan;         // update slacks against the broadcast row
        logic apply;        // apply delta to used/unused columns
        logic mark_used;    // mark the selected column as used
        logic set_owner;    // write owner of the selected column
    } t_cell_cmd;
endpackage
`default_nettype wire

// ----- rtl/mmca_cell.sv -----
// One column cell of the assignment row: holds the column's potential,
// owner, back link, slack and used flag, plus the matching target coordinates.
// Depends on mmca_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mmca_cell
    import mmca_pkg::*;
#(
    parameter int CW = 8,
    parameter int IW = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire logic [CW-1:0]    i_load_row,
    input  wire logic [CW-1:0]    i_load_col,
    input  wire logic             i_active,
    input  wire t_cell_cmd        i_cmd,
    input  wire logic             i_sel,
    input  wire logic [CW-1:0]    i_obj_row,
    input  wire logic [CW-1:0]    i_obj_col,
    input  wire logic [POT_W-1:0] i_row_pot,
    input  wire logic [IW-1:0]    i_cur_col,
    input  wire logic [POT_W-1:0] i_delta,
    input  wire logic [IW-1:0]    i_new_owner,
    // chain inputs from the left neighbor: running minimum and its column
    input  wire logic [POT_W-1:0] i_min,
    input  wire logic [IW-1:0]    i_min_idx,
    input  wire logic [IW-1:0]    i_my_idx,
    output logic [POT_W-1:0]      o_min,
    output logic [IW-1:0]         o_min_idx,
    output logic                  o_used,
    output logic [IW-1:0]         o_owner,
    output logic [IW-1:0]         o_link,
    output logic [POT_W-1:0]      o_pot
);
    logic [CW-1:0]    r_trow, r_tcol;
    logic [POT_W-1:0] r_pot, r_slack;
    logic [IW-1:0]    r_owner, r_link;
    logic             r_used;
    logic [POT_W-1:0] r_cmin;
    logic [IW-1:0]    r_cidx;
    logic [CW:0]      dr, dc;
    logic [POT_W-1:0] red, slack_now;

    always_comb begin
        dr = (i_obj_row >= r_trow) ? {1'b0, i_obj_row - r_trow} : {1'b0, r_trow - i_obj_row};
        dc = (i_obj_col >= r_tcol) ? {1'b0, i_obj_col - r_tcol} : {1'b0, r_tcol - i_obj_col};
        red = POT_W'(dr) + POT_W'(dc) - i_row_pot - r_pot;
        slack_now = ($signed(red) < $signed(r_slack)) ? red : r_slack;
    end

    // The running minimum moves one cell to the right per clock.
    always_ff @(posedge i_clk) begin
        if (i_active && !r_used && $signed(r_slack) < $signed(i_min)) begin
            r_cmin <= r_slack;
            r_cidx <= i_my_idx;
        end else begin
            r_cmin <= i_min;
            r_cidx <= i_min_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_trow <= i_load_row;
            r_tcol <= i_load_col;
        end
        if (!i_rst_n || i_cmd.init_solve) begin
            r_pot <= '0;
            r_owner <= '0;
            r_link <= '0;
            r_used <= 1'b0;
            r_slack <= BIG_SLACK;
        end else begin
            if (i_cmd.init_aug) begin
                r_slack <= BIG_SLACK;
                r_used <= 1'b0;
            end
            if (i_cmd.scan && i_active && !r_used) begin
                r_slack <= slack_now;
                if ($signed(red) < $signed(r_slack)) r_link <= i_cur_col;
            end
            if (i_cmd.apply) begin
                if (r_used) r_pot <= r_pot - i_delta;
                else r_slack <= r_slack - i_delta;
            end
            if (i_cmd.mark_used && i_sel) r_used <= 1'b1;
            if (i_cmd.set_owner && i_sel) r_owner <= i_new_owner;
        end
    end

    assign o_min = r_cmin;
    assign o_min_idx = r_cidx;
    assign o_used = r_used;
    assign o_owner = r_owner;
    assign o_link = r_link;
    assign o_pot = r_pot;
endmodule
`default_nettype wire

// ----- rtl/manhattan_min_cost_assignment_unit.sv -----
// Top level of the Manhattan min-cost assignment unit (Hungarian method).
// Load and clear transactions are accepted one per cycle while the unit is idle and o_stall is low.
// A solve with no objects or too few targets gives its result the cycle after acceptance.
// Otherwise a solve of n objects clears the row potentials, then for each row runs scan steps
// until a free column is reached, walks the path back, and finally reports the cost.
// Reset is synchronous, active low; counts, flags and controller return to idle.
`timescale 1ns / 1ps
`default_nettype none
module manhattan_min_cost_assignment_unit
    import mmca_pkg::*;
#(
    parameter int MAX_ITEMS = 32,
    parameter int COORD_WIDTH = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [1:0]        i_opcode,
    input  wire logic [7:0]        i_row,
    input  wire logic [7:0]        i_col,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [COST_W-1:0]      o_total_cost,
    output logic [1:0]             o_status
);
    localparam int IW = $clog2(MAX_ITEMS + 2);
    localparam int NC = MAX_ITEMS + 1;
    localparam int CW = (COORD_WIDTH < 8) ? COORD_WIDTH : 8;
    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

    localparam logic [3:0] S_IDLE = 4'd0, S_INIT = 4'd1, S_AUG = 4'd2, S_SCAN = 4'd3,
        S_WALK = 4'd4, S_DEC = 4'd5, S_APPLY = 4'd6, S_BACK = 4'd7, S_DONE = 4'd8,
        S_ROWPOT = 4'd9;

    logic [3:0]        r_state;
    logic [IW-1:0]     r_tcnt, r_ocnt, r_n, r_i, r_cur, r_walk;
    logic              r_ovf;
    logic [CW-1:0]     r_orow [MAX_ITEMS];
    logic [CW-1:0]     r_ocol [MAX_ITEMS];
    logic [POT_W-1:0]  r_rowpot [NC];
    logic [POT_W-1:0]  r_delta;
    logic [IW-1:0]     r_min_idx, r_owner_cur, r_rp_idx;
    logic [CW-1:0]     r_orow_cur, r_ocol_cur;
    logic [POT_W-1:0]  r_rowpot_cur;
    logic              r_rp_we;
    logic [IW-1:0]     r_rp_addr;
    logic [POT_W-1:0]  r_rp_data;
    logic [COST_W-1:0] r_cost;
    logic [1:0]        r_status;
    logic              r_oval;
    t_cell_cmd         cmd;

    logic [POT_W-1:0] c_min [NC+1];
    logic [IW-1:0]    c_idx [NC+1];
    logic             c_used [NC];
    logic [IW-1:0]    c_owner [NC];
    logic [IW-1:0]    c_link [NC];
    logic [POT_W-1:0] c_pot [NC];
    logic [POT_W-1:0] col0_pot;
    logic [IW-1:0]    cell_new_owner;
    logic [IW-1:0]    rp_col;

    wire acc = i_valid && !o_stall;
    wire [CW-1:0] in_r = i_row[CW-1:0];
    wire [CW-1:0] in_c = i_col[CW-1:0];
    wire tfull = (r_tcnt == IW'(MAX_ITEMS));
    wire ofull = (r_ocnt == IW'(MAX_ITEMS));
    wire [IW-1:0] own_m1 = r_owner_cur - 1'b1;

    assign o_stall = (r_state != S_IDLE) || (r_oval && i_stall);

    // Column cell 0 is the virtual column; cells 1..n carry targets.
    genvar g;
    generate
        for (g = 0; g < NC; g++) begin : g_cell
            mmca_cell #(.CW(CW), .IW(IW)) u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n),
                .i_load(g > 0 && acc && i_opcode == OP_TARGET && !tfull
                        && r_tcnt == IW'(g - 1)),
                .i_load_row(in_r), .i_load_col(in_c),
                .i_active(g > 0 && IW'(g) <= r_n),
                .i_cmd(cmd), .i_sel(r_cur == IW'(g)),
                .i_obj_row(r_orow_cur), .i_obj_col(r_ocol_cur),
                .i_row_pot(r_rowpot_cur), .i_cur_col(r_cur),
                .i_delta(r_delta), .i_new_owner(cell_new_owner),
                .i_min(c_min[g]), .i_min_idx(c_idx[g]), .i_my_idx(IW'(g)),
                .o_min(c_min[g+1]), .o_min_idx(c_idx[g+1]),
                .o_used(c_used[g]), .o_owner(c_owner[g]), .o_link(c_link[g]),
                .o_pot(c_pot[g])
            );
        end
    endgenerate
    assign c_min[0] = BIG_SLACK;
    assign c_idx[0] = '0;
    assign col0_pot = c_pot[0];

    // While walking the path back, each column takes the owner of its back link.
    assign cell_new_owner = (r_state == S_BACK) ? c_owner[c_link[r_cur]] : r_owner_cur;
    assign rp_col = (r_walk <= r_n) ? r_walk : '0;

    // A new row starts with column 0 current; later scan steps of the same row keep
    // their slacks and used flags.
    always_comb begin
        cmd = '0;
        cmd.init_solve = (r_state == S_INIT);
        cmd.init_aug   = (r_state == S_AUG) && (r_cur == '0);
        cmd.mark_used  = (r_state == S_AUG);
        cmd.set_owner  = (r_state == S_AUG) || (r_state == S_BACK);
        cmd.scan       = (r_state == S_SCAN);
        cmd.apply      = (r_state == S_APPLY);
    end

    always_ff @(posedge i_clk) begin
        if (acc && i_opcode == OP_OBJECT && !ofull) begin
            r_orow[r_ocnt[AW-1:0]] <= in_r;
            r_ocol[r_ocnt[AW-1:0]] <= in_c;
        end
        r_orow_cur <= (r_owner_cur != '0) ? r_orow[own_m1[AW-1:0]] : '0;
        r_ocol_cur <= (r_owner_cur != '0) ? r_ocol[own_m1[AW-1:0]] : '0;
        r_rowpot_cur <= r_rowpot[r_owner_cur];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tcnt <= '0; r_ocnt <= '0; r_ovf <= 1'b0; r_oval <= 1'b0;
            r_n <= '0; r_i <= '0; r_cur <= '0; r_walk <= '0;
            r_owner_cur <= '0; r_rp_idx <= '0; r_delta <= '0;
            r_min_idx <= '0;
            r_rp_we <= 1'b0; r_rp_addr <= '0; r_rp_data <= '0;
        end else begin
            if (r_oval && !i_stall) r_oval <= 1'b0;
            // Row potential update: read one column's owner entry, write it back next cycle.
            r_rp_we <= (r_state == S_ROWPOT) && (r_walk <= r_n) && c_used[rp_col];
            r_rp_addr <= c_owner[rp_col];
            r_rp_data <= r_rowpot[c_owner[rp_col]];
            if (r_rp_we) r_rowpot[r_rp_addr] <= r_rp_data + r_delta;
            case (r_state)
                S_IDLE: if (acc) begin
                    case (i_opcode)
                        OP_CLEAR: begin r_tcnt <= '0; r_ocnt <= '0; r_ovf <= 1'b0; end
                        OP_TARGET: if (tfull) r_ovf <= 1'b1; else r_tcnt <= r_tcnt + 1'b1;
                        OP_OBJECT: if (ofull) r_ovf <= 1'b1; else r_ocnt <= r_ocnt + 1'b1;
                        default: begin
                            r_n <= r_ocnt;
                            r_ocnt <= '0;
                            r_ovf <= 1'b0;
                            r_status <= (r_tcnt < r_ocnt) ? ST_SHORT
                                      : (r_ovf ? ST_OVERFLOW : ST_OK);
                            if (r_tcnt < r_ocnt || r_ocnt == '0) begin
                                r_cost <= '0;
                                r_oval <= 1'b1;
                            end else begin
                                r_state <= S_INIT;
                                r_rp_idx <= '0;
                            end
                        end
                    endcase
                end
                S_INIT: begin
                    r_rowpot[r_rp_idx] <= '0;
                    r_rp_idx <= r_rp_idx + 1'b1;
                    if (r_rp_idx == IW'(NC - 1)) begin
                        r_i <= IW'(1);
                        r_cur <= '0;
                        r_owner_cur <= IW'(1);
                        r_state <= S_AUG;
                    end
                end
                S_AUG: begin
                    // The current column is marked used; at a row start column 0 goes to row i.
                    r_walk <= '0;
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    // lets the owner's registered coordinates reach the cells
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_walk <= '0;
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    // The minimum passes through the register of every cell on its way to the end of the row.
                    if (r_walk != IW'(NC)) begin
                        r_walk <= r_walk + 1'b1;
                    end else begin
                        r_min_idx <= c_idx[NC];
                        r_delta <= c_min[NC];
                        if (c_idx[NC] == '0) begin
                            r_state <= S_BACK;
                        end else begin
                            r_state <= S_APPLY;
                        end
                    end
                end
                S_APPLY: begin
                    r_walk <= '0;
                    r_state <= S_ROWPOT;
                end
                S_ROWPOT: begin
                    // add delta to row potentials of rows owning used columns
                    if (r_walk <= r_n) begin
                        r_walk <= r_walk + 1'b1;
                    end else begin
                        r_cur <= r_min_idx;
                        if (c_owner[r_min_idx] == '0) begin
                            r_state <= S_BACK;
                        end else begin
                            r_owner_cur <= c_owner[r_min_idx];
                            r_state <= S_AUG;
                        end
                    end
                end
                S_BACK: begin
                    r_cur <= c_link[r_cur];
                    if (r_cur == '0) begin
                        if (r_i == r_n) begin
                            r_state <= S_DONE;
                        end else begin
                            r_i <= r_i + 1'b1;
                            r_owner_cur <= r_i + 1'b1;
                            r_state <= S_AUG;
                        end
                    end
                end
                S_DONE: begin
                    if ($signed(col0_pot) > 0) r_cost <= '0;
                    else if ((-col0_pot) > POT_W'(COST_MAX)) r_cost <= COST_MAX;
                    else r_cost <= COST_W'(-col0_pot);
                    r_oval <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_oval;
    assign o_total_cost = r_cost;
    assign o_status = r_status;

    a_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("busy but not stalling");
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tcnt <= IW'(MAX_ITEMS)) else $error("target count overflow");
    a_ocount_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= IW'(MAX_ITEMS)) else $error("object count overflow");
endmodule
`default_nettype wire

// ----- tb/sv/mmca_checker.sv -----
// Checker for the Manhattan min-cost assignment unit: watches both channels,
// predicts each solve result with a Hungarian-method model and compares it.
// Depends on mmca_pkg for opcodes, status codes and the cost width.
`timescale 1ns / 1ps
module mmca_checker
    import mmca_pkg::*;
#(
    parameter int MAX_ITEMS = 32,
    parameter int COORD_WIDTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_stall_in,
    input  logic [1:0]        i_opcode,
    input  logic [7:0]        i_row,
    input  logic [7:0]        i_col,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [COST_W-1:0] i_total_cost,
    input  logic [1:0]        i_status,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_solves_seen
);
    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic [1:0]        status;
    } solve_result_t;

    solve_result_t expected_results[$];
    int tgt_r[MAX_ITEMS], tgt_c[MAX_ITEMS], obj_r[MAX_ITEMS], obj_c[MAX_ITEMS];
    int tgt_count, obj_count;
    bit overflow_seen;

    function automatic int manhattan(int o, int t);
        int dr, dc;
        dr = obj_r[o] - tgt_r[t];
        dc = obj_c[o] - tgt_c[t];
        if (dr < 0) dr = -dr;
        if (dc < 0) dc = -dc;
        return dr + dc;
    endfunction

    // Potential-based Hungarian method over n objects and the first n targets.
    function automatic longint min_assignment_cost(int n);
        longint u[MAX_ITEMS+1], v[MAX_ITEMS+1], minv[MAX_ITEMS+1];
        int p[MAX_ITEMS+1], way[MAX_ITEMS+1];
        bit used[MAX_ITEMS+1];
        int j0, j1, i0;
        longint delta, red;
        for (int j = 0; j <= n; j++) begin
            u[j] = 0; v[j] = 0; p[j] = 0; way[j] = 0;
        end
        for (int i = 1; i <= n; i++) begin
            j0 = 0;
            p[0] = i;
            for (int j = 0; j <= n; j++) begin
                minv[j] = 64'd1000000007;
                used[j] = 0;
            end
            do begin
                j1 = 0;
                delta = 64'd1000000007;
                used[j0] = 1;
                i0 = p[j0];
                for (int j = 1; j <= n; j++) begin
                    if (!used[j]) begin
                        red = manhattan(i0 - 1, j - 1) - u[i0] - v[j];
                        if (red < minv[j]) begin
                            minv[j] = red;
                            way[j] = j0;
                        end
                        if (minv[j] < delta) begin
                            delta = minv[j];
                            j1 = j;
                        end
                    end
                end
                if (j1 == 0) break;
                for (int j = 0; j <= n; j++) begin
                    if (used[j]) begin
                        u[p[j]] += delta;
                        v[j] -= delta;
                    end else begin
                        minv[j] -= delta;
                    end
                end
                j0 = j1;
            end while (p[j0] != 0);
            do begin
                j1 = way[j0];
                p[j0] = p[j1];
                j0 = j1;
            end while (j0 != 0);
        end
        return -v[0];
    endfunction

    task automatic apply_transaction(logic [1:0] op, int r, int c);
        solve_result_t res;
        longint cost;
        r = r & ((1 << COORD_WIDTH) - 1);
        c = c & ((1 << COORD_WIDTH) - 1);
        case (op)
            OP_CLEAR: begin
                tgt_count = 0; obj_count = 0; overflow_seen = 0;
            end
            OP_TARGET: begin
                if (tgt_count < MAX_ITEMS) begin
                    tgt_r[tgt_count] = r; tgt_c[tgt_count] = c; tgt_count++;
                end else overflow_seen = 1;
            end
            OP_OBJECT: begin
                if (obj_count < MAX_ITEMS) begin
                    obj_r[obj_count] = r; obj_c[obj_count] = c; obj_count++;
                end else overflow_seen = 1;
            end
            default: begin
                cost = 0;
                if (tgt_count < obj_count) begin
                    res.status = ST_SHORT;
                end else begin
                    res.status = overflow_seen ? ST_OVERFLOW : ST_OK;
                    if (obj_count > 0) cost = min_assignment_cost(obj_count);
                    if (cost < 0) cost = 0;
                    if (cost > COST_MAX) cost = COST_MAX;
                end
                res.cost = cost[COST_W-1:0];
                expected_results = {expected_results, res};
                obj_count = 0;
                overflow_seen = 0;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        solve_result_t exp_res;
        if (!i_rst_n) begin
            tgt_count = 0; obj_count = 0; overflow_seen = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_solves_seen <= o_solves_seen + 1;
                if (expected_results.size() == 0) begin
                    $error("unexpected result: total_cost %0d status %0d",
                           i_total_cost, i_status);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (exp_res.cost !== i_total_cost) begin
                        $error("total_cost: expected %0d, actual %0d",
                               exp_res.cost, i_total_cost);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (exp_res.status !== i_status) begin
                        $error("status: expected %0d, actual %0d",
                               exp_res.status, i_status);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_valid && !i_stall_in) apply_transaction(i_opcode, i_row, i_col);
        end
        o_pending <= expected_results.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_solves_seen = 0;
    end
endmodule

// ----- tb/sv/tb_manhattan_min_cost_assignment_unit.sv -----
// Testbench top for the Manhattan min-cost assignment unit: drives load, clear
// and solve transactions with random idling and gives the verdict.
// Depends on mmca_pkg, the unit under test and mmca_checker.
`timescale 1ns / 1ps
module tb_manhattan_min_cost_assignment_unit;
    import mmca_pkg::*;

    localparam int WATCHDOG_LIMIT = 400000;

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_valid = 0;
    logic              o_stall;
    logic [1:0]        i_opcode = OP_CLEAR;
    logic [7:0]        i_row = 0;
    logic [7:0]        i_col = 0;
    logic              o_valid;
    logic              i_stall = 0;
    logic [COST_W-1:0] o_total_cost;
    logic [1:0]        o_status;
    int                fail_count, pending, solves_seen;
    int                idle_cycles;
    int                sent_count = 0;
    bit                quiet_phase = 0;

    always #5 i_clk = ~i_clk;

    manhattan_min_cost_assignment_unit u_top (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_opcode, .i_row, .i_col,
        .o_valid, .i_stall, .o_total_cost, .o_status
    );

    mmca_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .i_stall_in(o_stall), .i_opcode, .i_row,
        .i_col, .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_total_cost(o_total_cost), .i_status(o_status),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_solves_seen(solves_seen)
    );

    // Receiver stalls at random moments, in bursts whose length is drawn at random.
    always @(posedge i_clk) begin
        if (quiet_phase || !i_rst_n) begin
            i_stall <= 0;
        end else if (i_stall) begin
            if (idle_cycles > 1) idle_cycles <= idle_cycles - 1;
            else i_stall <= 0;
        end else if ($urandom_range(0, 5) == 0) begin
            i_stall <= 1;
            idle_cycles <= $urandom_range(1, 4);
        end
    end

    // Watchdog: cycles with no accepted transaction on either side.
    always @(posedge i_clk) begin
        int quiet;
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet = 0;
        else quiet++;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("timeout");
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send(logic [1:0] op, logic [7:0] r, logic [7:0] c);
        int gap;
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        i_opcode <= op;
        i_row <= r;
        i_col <= c;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0 || u_checker.expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // One random problem: mostly small sizes, sometimes up to full capacity, at times short of targets.
    task automatic random_problem();
        int nt, no, extra;
        bit wide;
        wide = ($urandom_range(0, 3) == 0);
        extra = $urandom_range(0, 9);
        if (extra == 0) no = $urandom_range(0, 32);
        else no = $urandom_range(0, 6);
        nt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, no) :
             no + $urandom_range(0, 3);
        if ($urandom_range(0, 1)) send(OP_CLEAR, 8'($urandom), 8'($urandom));
        for (int k = 0; k < nt; k++)
            send(OP_TARGET, 8'(wide ? $urandom : $urandom_range(0, 15)),
                 8'(wide ? $urandom : $urandom_range(0, 15)));
        for (int k = 0; k < no; k++)
            send(OP_OBJECT, 8'(wide ? $urandom : $urandom_range(0, 15)),
                 8'(wide ? $urandom : $urandom_range(0, 15)));
        if ($urandom_range(0, 15) == 0) send(OP_OBJECT, 8'($urandom), 8'($urandom));
        send(OP_SOLVE, 8'($urandom), 8'($urandom));
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: empty solve, corner coordinates, short targets, short after a clear.
        send(OP_SOLVE, 8'h00, 8'h00);
        send(OP_TARGET, 8'h00, 8'h00);
        send(OP_TARGET, 8'hff, 8'hff);
        send(OP_OBJECT, 8'hff, 8'h00);
        send(OP_OBJECT, 8'h00, 8'hff);
        send(OP_SOLVE, 8'hff, 8'hff);
        send(OP_OBJECT, 8'h55, 8'haa);
        send(OP_OBJECT, 8'haa, 8'h55);
        send(OP_OBJECT, 8'h01, 8'h02);
        send(OP_SOLVE, 8'h00, 8'h00);
        send(OP_OBJECT, 8'h80, 8'h7f);
        send(OP_CLEAR, 8'hff, 8'hff);
        send(OP_OBJECT, 8'h10, 8'h10);
        send(OP_SOLVE, 8'h00, 8'h00);
        drain();
        // Fill the target store past capacity, then solve one object.
        for (int k = 0; k < 33; k++) send(OP_TARGET, 8'(k * 7), 8'(255 - k * 5));
        send(OP_OBJECT, 8'hff, 8'hff);
        send(OP_SOLVE, 8'h00, 8'h00);
        // Full object store plus one overflow, against 32 targets.
        for (int k = 0; k < 33; k++) send(OP_OBJECT, 8'($urandom), 8'($urandom));
        send(OP_SOLVE, 8'h00, 8'h00);
        // Pause until every expected result has come.
        drain();

        while (sent_count < 1850) begin
            if (sent_count > 1600) quiet_phase = 1;
            if ($urandom_range(0, 9) == 0) begin
                send(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
            end else begin
                random_problem();
            end
        end
        drain();
        repeat (50) @(posedge i_clk);
        $display("covered %0d transactions and %0d solve results", sent_count,
                 solves_seen);
        $display("sizes from empty to full capacity, short target sets and overflow");
        if (fail_count == 0 && u_checker.expected_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
